// ===== src/argtok_pkg.sv =====
// Shared types, constants and character helpers of the argument tokenizer.
package argtok_pkg;

   typedef enum logic [2:0] {
      MODE_START,
      MODE_WORD,
      MODE_QUOTED,
      MODE_ESCAPE,
      MODE_OCTAL,
      MODE_HEX,
      MODE_CLOSED
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_END,
      KIND_LINE
   } kind_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [7:0] token_count;
      logic       last;
   } rsp_type;

   // results of one step: how many (0 to 2) and the results themselves
   typedef struct packed {
      logic [1:0] n;
      rsp_type    res0;
      rsp_type    res1;
   } step_out_type;

   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [1:0] ESC_DIGITS = 2'd2;

   function automatic rsp_type make_rsp(kind_type kind, logic [7:0] data, logic [7:0] count);
      rsp_type r;
      r.kind        = kind;
      r.data        = data;
      r.token_count = count;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_octal(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h37);
   endfunction

   // bit 4: character is a hex digit, bits 3:0: its value
   function automatic logic [4:0] hex_digit(logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // bit 8: character is a named escape, bits 7:0: the byte it stands for
   function automatic logic [8:0] named_escape(logic [7:0] c);
      logic [8:0] r;
      unique case (c)
         8'h6E:   r = {1'b1, 8'd10};
         8'h72:   r = {1'b1, 8'd13};
         8'h74:   r = {1'b1, 8'd9};
         8'h62:   r = {1'b1, 8'd8};
         8'h61:   r = {1'b1, 8'd7};
         8'h66:   r = {1'b1, 8'd12};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/argtok_parser.sv =====
// Parse state registers and the per-character step logic of the tokenizer.
module argtok_parser
   import argtok_pkg::*;
#(
   parameter int MAX_TOKENS = 255
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_type      item,
   output step_out_type res_o
);

   localparam int CAP = (MAX_TOKENS < 255) ? MAX_TOKENS : 255;
   localparam logic [7:0] CAP_W = 8'(CAP);

   mode_type   mode_ff, mode_in;
   logic       qdbl_ff, qdbl_in;
   logic [8:0] esc_ff, esc_in;
   logic [1:0] digits_ff, digits_in;
   logic       nonempty_ff, nonempty_in;
   logic [7:0] seen_ff, seen_in;

   logic [7:0] c;
   logic [7:0] seen_inc;
   logic       c_space, c_quote, q_esc, q_close;
   logic [4:0] hex_d;
   logic [8:0] named_d;
   logic [8:0] oct_val, hex_val;
   logic [1:0] n;
   rsp_type    res0, res1;

   assign c        = item.ch;
   assign seen_inc = (seen_ff < CAP_W) ? (seen_ff + 8'd1) : seen_ff;
   assign c_space  = is_space(c);
   assign c_quote  = (c == CH_DQUOTE) || (c == CH_SQUOTE);
   assign q_esc    = (c == CH_BSLASH) && qdbl_ff;
   assign q_close  = (c == (qdbl_ff ? CH_DQUOTE : CH_SQUOTE));
   assign hex_d    = hex_digit(c);
   assign named_d  = named_escape(c);
   assign oct_val  = {esc_ff[5:0], c[2:0]};
   assign hex_val  = {esc_ff[4:0], hex_d[3:0]};

   always_comb begin
      mode_in     = mode_ff;
      qdbl_in     = qdbl_ff;
      esc_in      = esc_ff;
      digits_in   = digits_ff;
      nonempty_in = nonempty_ff;
      seen_in     = seen_ff;
      n           = 2'd0;
      res0        = make_rsp(KIND_BYTE, 8'd0, 8'd0);
      res1        = make_rsp(KIND_BYTE, 8'd0, 8'd0);
      if (step) begin
         if (item.line_end) begin
            if (nonempty_ff) begin
               res0 = make_rsp(KIND_END, 8'd0, 8'd0);
               res1 = make_rsp(KIND_LINE, 8'd0, seen_inc);
               n    = 2'd2;
            end else begin
               res0 = make_rsp(KIND_LINE, 8'd0, seen_ff);
               n    = 2'd1;
            end
            mode_in     = MODE_START;
            qdbl_in     = 1'b0;
            esc_in      = 9'd0;
            digits_in   = 2'd0;
            nonempty_in = 1'b0;
            seen_in     = 8'd0;
         end else if (c != 8'd0) begin
            unique case (mode_ff)
               MODE_WORD: begin
                  if (c_space) begin
                     res0        = make_rsp(KIND_END, 8'd0, 8'd0);
                     seen_in     = seen_inc;
                     nonempty_in = 1'b0;
                     mode_in     = MODE_START;
                  end else begin
                     res0        = make_rsp(KIND_BYTE, c, 8'd0);
                     nonempty_in = 1'b1;
                  end
                  n = 2'd1;
               end
               MODE_QUOTED: begin
                  if (q_esc) begin
                     mode_in = MODE_ESCAPE;
                  end else if (q_close) begin
                     mode_in = MODE_CLOSED;
                  end else begin
                     res0        = make_rsp(KIND_BYTE, c, 8'd0);
                     nonempty_in = 1'b1;
                     n           = 2'd1;
                  end
               end
               MODE_ESCAPE: begin
                  mode_in = MODE_QUOTED;
                  if (named_d[8]) begin
                     res0        = make_rsp(KIND_BYTE, named_d[7:0], 8'd0);
                     nonempty_in = 1'b1;
                     n           = 2'd1;
                  end else if (is_octal(c)) begin
                     esc_in    = {6'd0, c[2:0]};
                     digits_in = ESC_DIGITS;
                     mode_in   = MODE_OCTAL;
                  end else if (c == CH_X) begin
                     esc_in    = 9'd0;
                     digits_in = ESC_DIGITS;
                     mode_in   = MODE_HEX;
                  end else begin
                     res0        = make_rsp(KIND_BYTE, c, 8'd0);
                     nonempty_in = 1'b1;
                     n           = 2'd1;
                  end
               end
               MODE_OCTAL, MODE_HEX: begin
                  if ((mode_ff == MODE_OCTAL) ? is_octal(c) : hex_d[4]) begin
                     esc_in    = (mode_ff == MODE_OCTAL) ? oct_val : hex_val;
                     digits_in = digits_ff - 2'd1;
                     if (digits_ff == 2'd1) begin
                        res0        = make_rsp(KIND_BYTE, esc_in[7:0], 8'd0);
                        nonempty_in = 1'b1;
                        mode_in     = MODE_QUOTED;
                        n           = 2'd1;
                     end
                  end else begin
                     // emit the escape, then treat the character inside the quotes
                     res0        = make_rsp(KIND_BYTE, esc_ff[7:0], 8'd0);
                     nonempty_in = 1'b1;
                     n           = 2'd1;
                     if (q_esc) begin
                        mode_in = MODE_ESCAPE;
                     end else if (q_close) begin
                        mode_in = MODE_CLOSED;
                     end else begin
                        mode_in = MODE_QUOTED;
                        res1    = make_rsp(KIND_BYTE, c, 8'd0);
                        n       = 2'd2;
                     end
                  end
               end
               MODE_CLOSED: begin
                  // commit the quoted token, then treat the character between tokens
                  res0        = make_rsp(KIND_END, 8'd0, 8'd0);
                  seen_in     = seen_inc;
                  nonempty_in = 1'b0;
                  mode_in     = MODE_START;
                  n           = 2'd1;
                  if (!c_space) begin
                     if (c_quote) begin
                        qdbl_in = (c == CH_DQUOTE);
                        mode_in = MODE_QUOTED;
                     end else begin
                        mode_in     = MODE_WORD;
                        res1        = make_rsp(KIND_BYTE, c, 8'd0);
                        nonempty_in = 1'b1;
                        n           = 2'd2;
                     end
                  end
               end
               default: begin
                  mode_in = MODE_START;
                  if (!c_space) begin
                     if (c_quote) begin
                        qdbl_in = (c == CH_DQUOTE);
                        mode_in = MODE_QUOTED;
                     end else begin
                        mode_in     = MODE_WORD;
                        res0        = make_rsp(KIND_BYTE, c, 8'd0);
                        nonempty_in = 1'b1;
                        n           = 2'd1;
                     end
                  end
               end
            endcase
         end
      end
      res0.last  = (n == 2'd1);
      res1.last  = 1'b1;
      res_o.n    = n;
      res_o.res0 = res0;
      res_o.res1 = res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_START;
         qdbl_ff     <= 1'b0;
         esc_ff      <= 9'd0;
         digits_ff   <= 2'd0;
         nonempty_ff <= 1'b0;
         seen_ff     <= 8'd0;
      end else begin
         mode_ff     <= mode_in;
         qdbl_ff     <= qdbl_in;
         esc_ff      <= esc_in;
         digits_ff   <= digits_in;
         nonempty_ff <= nonempty_in;
         seen_ff     <= seen_in;
      end
   end

endmodule

// ===== src/argtok_out_buf.sv =====
// Two-entry result register that drains one transfer per cycle while rsp_stall is low.
module argtok_out_buf
   import argtok_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  step_out_type res_i,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic [1:0] cnt_ff, cnt_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic       pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         cnt_in   = res_i.n;
         slot0_in = res_i.res0;
         slot1_in = res_i.res1;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ===== src/shell_argument_tokenizer_top.sv =====
// Top level of the shell-style argument tokenizer.
// Takes one command-line character per transfer on the req_ channel and streams
// argument tokens on the rsp_ channel: token bytes, a token-end marker after each
// token and a line-done result carrying the saturating token count when an item
// with line_end arrives. Unquoted words split on whitespace; single and double
// quotes open quoted tokens, and double quotes honour backslash escapes (named,
// up to three octal digits, x with up to two hex digits). An item is held in an
// input register, parsed, and its zero, one or two results are written into a
// two-entry result register, so the first result is offered on rsp_ once it has
// passed both the input register and the result register. Throughput is one
// character per cycle while neither rsp_stall nor a full result register holds
// the flow; an item that yields two results holds the next item in the input
// register while the result register drains one transfer per cycle, unless stalled.
// Items with a zero character and no line end produce no result.
module shell_argument_tokenizer_top
   import argtok_pkg::*;
#(
   parameter int MAX_TOKENS = 255
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic         in_vld_ff, in_vld_in;
   req_type      in_data_ff;
   logic         room;
   logic         adv;
   step_out_type step_res;

   // advance the held item once the result register can take all its results
   assign adv       = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   argtok_parser #(
      .MAX_TOKENS (MAX_TOKENS)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .step  (adv),
      .item  (in_data_ff),
      .res_o (step_res)
   );

   argtok_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (adv),
      .res_i     (step_res),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // hold a blocked item in the input register
   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !room) |=> (in_vld_ff && $stable(in_data_ff)))
      else $error("blocked input item lost or changed");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind != KIND_BYTE)) |-> (rsp_data.data == 8'd0))
      else $error("marker result carries data");

   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind != KIND_LINE)) |-> (rsp_data.token_count == 8'd0))
      else $error("token count outside line done");

   a_line_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.kind == KIND_LINE)) |-> rsp_data.last)
      else $error("line done not marked last");

endmodule
